/* design/i2cseq_pkg.sv */
// Shared types, codes and phase tables for the I2C master byte sequencer.
package i2cseq_pkg;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		BUS_EEPROM = 2'd0,
		BUS_VOICE  = 2'd1,
		BUS_FM     = 2'd2
	} bus_t;

	typedef enum logic [1:0] {
		WS_BIT,
		WS_SCL_HI,
		WS_SCL_LO
	} wr_slot_t;

	localparam int PIN_EE_SCL = 0;
	localparam int PIN_EE_SDA = 1;
	localparam int PIN_EE_DRV = 2;
	localparam int PIN_RA_SDA = 3;
	localparam int PIN_RA_DRV = 4;
	localparam int PIN_FM_SCL = 5;
	localparam int PIN_VO_SCL = 6;
	localparam int NUM_PINS   = 7;

	localparam int PHASE_W = 5;

	localparam logic [PHASE_W-1:0] START_LAST = 5'd3;
	localparam logic [PHASE_W-1:0] STOP_LAST  = 5'd3;
	localparam logic [PHASE_W-1:0] WRITE_LAST = 5'd30;
	localparam logic [PHASE_W-1:0] READ_LAST  = 5'd21;

	typedef struct packed {
		op_t                  cmd;
		logic [PHASE_W-1:0]   phase;
		logic [7:0]           shift;
		logic                 nack;
		logic [NUM_PINS-1:0]  pins;
		logic [7:0]           rx;
		logic                 ack;
	} seq_state_t;

	// slot within the three-phase bit cell of a write, phases 1 to 24
	function automatic wr_slot_t wr_slot(input logic [PHASE_W-1:0] p);
		wr_slot_t s;
		case (p)
			5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22: s = WS_BIT;
			5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23: s = WS_SCL_HI;
			default: s = WS_SCL_LO;
		endcase
		return s;
	endfunction

endpackage

/* design/i2cseq_step.sv */
// Next-state logic: one bus phase of the active command per beat.
module i2cseq_step
	import i2cseq_pkg::*;
(
	input  seq_state_t  cur,
	input  logic [2:0]  operation,
	input  logic [7:0]  tx_byte,
	input  logic        nack_after_read,
	input  logic        ee_data_in,
	input  logic        radio_sda_in,
	input  logic [1:0]  target_bus,
	output seq_state_t  nxt,
	output logic        done
);

	logic                scl_wr, scl_lvl;
	logic                sda_wr, sda_lvl;
	logic                drv_wr, drv_lvl;
	logic                sda_smp;
	logic                last;
	logic [PHASE_W-1:0]  ph;

	always_comb begin
		nxt     = cur;
		done    = 1'b0;
		scl_wr  = 1'b0;
		scl_lvl = 1'b0;
		sda_wr  = 1'b0;
		sda_lvl = 1'b0;
		drv_wr  = 1'b0;
		drv_lvl = 1'b0;
		last    = 1'b0;

		case (target_bus)
			BUS_EEPROM:        sda_smp = ee_data_in;
			BUS_VOICE, BUS_FM: sda_smp = radio_sda_in;
			default:           sda_smp = 1'b0;
		endcase

		if (cur.cmd == OP_NONE) begin
			case (operation)
				OP_START: begin
					nxt.cmd   = OP_START;
					nxt.phase = '0;
				end
				OP_STOP: begin
					nxt.cmd   = OP_STOP;
					nxt.phase = '0;
				end
				OP_WRITE: begin
					nxt.cmd   = OP_WRITE;
					nxt.phase = '0;
					nxt.shift = tx_byte;
				end
				OP_READ: begin
					nxt.cmd   = OP_READ;
					nxt.phase = '0;
					nxt.shift = '0;
					nxt.nack  = nack_after_read;
				end
				default: ;
			endcase
		end

		ph = nxt.phase;

		case (nxt.cmd)
			OP_START: begin
				case (ph)
					5'd0: begin sda_wr = 1'b1; sda_lvl = 1'b1; end
					5'd1: begin scl_wr = 1'b1; scl_lvl = 1'b1; end
					5'd2: begin sda_wr = 1'b1; sda_lvl = 1'b0; end
					default: begin scl_wr = 1'b1; scl_lvl = 1'b0; end
				endcase
				last = (ph >= START_LAST);
			end
			OP_STOP: begin
				case (ph)
					5'd0: begin scl_wr = 1'b1; scl_lvl = 1'b0; end
					5'd1: begin sda_wr = 1'b1; sda_lvl = 1'b0; end
					5'd2: begin scl_wr = 1'b1; scl_lvl = 1'b1; end
					default: begin sda_wr = 1'b1; sda_lvl = 1'b1; end
				endcase
				last = (ph >= STOP_LAST);
			end
			OP_WRITE: begin
				if (ph == 5'd0) begin
					scl_wr = 1'b1;
				end else if (ph <= 5'd24) begin
					case (wr_slot(ph))
						WS_BIT: begin
							sda_wr    = 1'b1;
							sda_lvl   = nxt.shift[7];
							nxt.shift = {nxt.shift[6:0], 1'b0};
						end
						WS_SCL_HI: begin scl_wr = 1'b1; scl_lvl = 1'b1; end
						default:   scl_wr = 1'b1;
					endcase
				end else begin
					case (ph)
						5'd25: drv_wr = 1'b1;
						5'd26: begin sda_wr = 1'b1; sda_lvl = 1'b1; end
						5'd27: begin
							scl_wr  = 1'b1;
							scl_lvl = 1'b1;
							nxt.ack = ~sda_smp;
						end
						5'd28: scl_wr = 1'b1;
						5'd29: begin drv_wr = 1'b1; drv_lvl = 1'b1; end
						default: begin sda_wr = 1'b1; sda_lvl = 1'b1; end
					endcase
				end
				last = (ph >= WRITE_LAST);
			end
			OP_READ: begin
				if (ph == 5'd0) begin
					drv_wr = 1'b1;
				end else if (ph <= 5'd16) begin
					scl_wr = 1'b1;
					if (!ph[0]) begin
						scl_lvl   = 1'b1;
						nxt.shift = {nxt.shift[6:0], sda_smp};
					end
				end else begin
					case (ph)
						5'd17: scl_wr = 1'b1;
						5'd18: begin drv_wr = 1'b1; drv_lvl = 1'b1; end
						5'd19: begin sda_wr = 1'b1; sda_lvl = nxt.nack; end
						5'd20: begin scl_wr = 1'b1; scl_lvl = 1'b1; end
						default: begin
							scl_wr = 1'b1;
							nxt.rx = nxt.shift;
						end
					endcase
				end
				last = (ph >= READ_LAST);
			end
			default: ;
		endcase

		if (scl_wr) begin
			case (target_bus)
				BUS_EEPROM: nxt.pins[PIN_EE_SCL] = scl_lvl;
				BUS_VOICE:  nxt.pins[PIN_VO_SCL] = scl_lvl;
				BUS_FM:     nxt.pins[PIN_FM_SCL] = scl_lvl;
				default: ;
			endcase
		end
		if (sda_wr) begin
			case (target_bus)
				BUS_EEPROM:        nxt.pins[PIN_EE_SDA] = sda_lvl;
				BUS_VOICE, BUS_FM: nxt.pins[PIN_RA_SDA] = sda_lvl;
				default: ;
			endcase
		end
		if (drv_wr) begin
			case (target_bus)
				BUS_EEPROM:        nxt.pins[PIN_EE_DRV] = drv_lvl;
				BUS_VOICE, BUS_FM: nxt.pins[PIN_RA_DRV] = drv_lvl;
				default: ;
			endcase
		end

		if (nxt.cmd != OP_NONE) begin
			if (last) begin
				nxt.cmd   = OP_NONE;
				nxt.phase = '0;
				done      = 1'b1;
			end else begin
				nxt.phase = ph + 5'd1;
			end
		end
	end

endmodule

/* design/i2c_master_byte_sequencer.sv */
// Top level: input register, sequencer state, result register.
//
//  channel  dir  data                                       width
//  s_axis   in   tick beat with optional command            16
//  m_axis   out  pin levels, busy/done, rx byte, ack        24
//  cfg      in   target bus select                          2
//
// One result beat per input beat, via the input and result registers; one
// beat per cycle while m_axis does not stall. The step logic runs when the
// input register holds a beat and the result register is free or draining.
// arst_n clears valid flags, the command and counters; pins reset high and
// driven. A stalled m_axis holds the input register and then s_axis_tready.
module i2c_master_byte_sequencer
	import i2cseq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] operation, [10:3] tx_byte, [11] nack_after_read,
	// [12] ee_data_in, [13] radio_sda_in, [15:14] zero
	input  logic [15:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] eeprom_scl, [1] ee_data, [2] ee_data_drive, [3] radio_sda,
	// [4] radio_sda_drive, [5] fm_scl, [6] voice_scl, [7] busy_res,
	// [8] done_res, [16:9] rx_byte, [17] ack_received, [23:18] zero
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_wdata
);

	logic        valid_s1;
	logic [13:0] item_s1;
	logic        out_valid_q;
	logic [23:0] out_data_q;
	logic [1:0]  target_bus_q;
	seq_state_t  state_q;
	seq_state_t  state_nxt;
	logic        done;
	logic        advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_bus_q <= BUS_EEPROM;
		end else if (cfg_wen) begin
			target_bus_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= s_axis_tdata[13:0];
		end
	end

	i2cseq_step u_step (
		.cur             (state_q),
		.operation       (item_s1[2:0]),
		.tx_byte         (item_s1[10:3]),
		.nack_after_read (item_s1[11]),
		.ee_data_in      (item_s1[12]),
		.radio_sda_in    (item_s1[13]),
		.target_bus      (target_bus_q),
		.nxt             (state_nxt),
		.done            (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cmd   <= OP_NONE;
			state_q.phase <= '0;
			state_q.shift <= '0;
			state_q.nack  <= 1'b0;
			state_q.pins  <= '1;
			state_q.rx    <= '0;
			state_q.ack   <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {6'd0, state_nxt.ack, state_nxt.rx, done,
				(state_nxt.cmd != OP_NONE), state_nxt.pins};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_idle_phase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.cmd == OP_NONE) |-> (state_q.phase == '0))
		else $error("idle with nonzero phase");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase <= WRITE_LAST)
		else $error("phase counter out of range");

	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.cmd != OP_NONE) |=>
		(state_q.phase == $past(state_q.phase) + 5'd1 || state_q.phase == '0))
		else $error("phase did not advance by one");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[8]) |-> !out_data_q[7])
		else $error("done and busy together");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the I2C master byte sequencer: predictor and scoreboard.
`timescale 1ns / 100ps

module tb_top;
	import i2cseq_pkg::*;

	typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_t;

	localparam int QUIET_LIMIT = 1000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_wdata = '0;

	// predictor state
	logic [1:0] tgt = BUS_EEPROM;
	op_t        cur_cmd = OP_NONE;
	int         phase = 0;
	logic [7:0] shreg = '0;
	logic       nack_f = 1'b0;
	logic [6:0] pins = 7'h7F;
	logic [7:0] rx_q = '0;
	logic       ack_q = 1'b0;

	logic [23:0] bus_words_due [$];

	int send_idle_pct = 0;
	int ready_stall_pct = 0;
	int noise_pct = 0;
	int retarget_pct = 0;

	int beats_sent = 0;
	int results_seen = 0;
	int mismatch_cnt = 0;
	int quiet_cycles = 0;
	int n_start = 0, n_stop = 0, n_write = 0, n_read = 0;
	int n_acked = 0, n_read_nack = 0, n_ignored = 0, n_retarget = 0;

	string field_name [0:11] = '{"eeprom_scl", "ee_data", "ee_data_drive", "radio_sda",
		"radio_sda_drive", "fm_scl", "voice_scl", "busy", "done", "rx_byte", "ack", "pad"};
	int field_lsb [0:11] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 17, 18};
	int field_w [0:11] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 8, 1, 6};

	i2c_master_byte_sequencer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void put_scl(input logic lvl);
		case (tgt)
			BUS_EEPROM: pins[PIN_EE_SCL] = lvl;
			BUS_VOICE:  pins[PIN_VO_SCL] = lvl;
			BUS_FM:     pins[PIN_FM_SCL] = lvl;
			default: ;
		endcase
	endfunction

	function automatic void put_sda(input logic lvl);
		case (tgt)
			BUS_EEPROM:        pins[PIN_EE_SDA] = lvl;
			BUS_VOICE, BUS_FM: pins[PIN_RA_SDA] = lvl;
			default: ;
		endcase
	endfunction

	function automatic void put_dir(input logic drive);
		case (tgt)
			BUS_EEPROM:        pins[PIN_EE_DRV] = drive;
			BUS_VOICE, BUS_FM: pins[PIN_RA_DRV] = drive;
			default: ;
		endcase
	endfunction

	// one bus phase per beat; returns the expected result word
	function automatic logic [23:0] advance_bus_phase(input logic [15:0] beat);
		logic [2:0]  op;
		logic        line_in;
		logic        last;
		logic [23:0] word;
		op = beat[2:0];
		last = 1'b0;
		case (tgt)
			BUS_EEPROM:        line_in = beat[12];
			BUS_VOICE, BUS_FM: line_in = beat[13];
			default:           line_in = 1'b0;
		endcase
		if (op >= OP_START && op <= OP_READ) begin
			if (cur_cmd == OP_NONE) begin
				cur_cmd = op_t'(op);
				phase = 0;
				case (cur_cmd)
					OP_START: n_start++;
					OP_STOP:  n_stop++;
					OP_WRITE: begin
						shreg = beat[10:3];
						n_write++;
					end
					default: begin
						shreg = '0;
						nack_f = beat[11];
						n_read++;
						n_read_nack += beat[11];
					end
				endcase
			end else begin
				n_ignored++;
			end
		end
		case (cur_cmd)
			OP_START: begin
				case (phase)
					0: put_sda(1'b1);
					1: put_scl(1'b1);
					2: put_sda(1'b0);
					default: put_scl(1'b0);
				endcase
				last = (phase == 3);
			end
			OP_STOP: begin
				case (phase)
					0: put_scl(1'b0);
					1: put_sda(1'b0);
					2: put_scl(1'b1);
					default: put_sda(1'b1);
				endcase
				last = (phase == 3);
			end
			OP_WRITE: begin
				if (phase == 0) begin
					put_scl(1'b0);
				end else if (phase <= 24) begin
					case ((phase - 1) % 3)
						0: begin
							put_sda(shreg[7]);
							shreg = shreg << 1;
						end
						1: put_scl(1'b1);
						default: put_scl(1'b0);
					endcase
				end else begin
					case (phase)
						25: put_dir(1'b0);
						26: put_sda(1'b1);
						27: begin
							put_scl(1'b1);
							ack_q = ~line_in;
							n_acked += ack_q;
						end
						28: put_scl(1'b0);
						29: put_dir(1'b1);
						default: put_sda(1'b1);
					endcase
				end
				last = (phase == 30);
			end
			OP_READ: begin
				if (phase == 0) begin
					put_dir(1'b0);
				end else if (phase <= 16) begin
					if ((phase - 1) % 2 == 0) begin
						put_scl(1'b0);
					end else begin
						put_scl(1'b1);
						shreg = {shreg[6:0], line_in};
					end
				end else begin
					case (phase)
						17: put_scl(1'b0);
						18: put_dir(1'b1);
						19: put_sda(nack_f);
						20: put_scl(1'b1);
						default: begin
							put_scl(1'b0);
							rx_q = shreg;
						end
					endcase
				end
				last = (phase == 21);
			end
			default: ;
		endcase
		if (last) begin
			cur_cmd = OP_NONE;
			phase = 0;
		end else if (cur_cmd != OP_NONE) begin
			phase++;
		end
		word = '0;
		word[6:0] = pins;
		word[7] = (cur_cmd != OP_NONE);
		word[8] = last;
		word[16:9] = rx_q;
		word[17] = ack_q;
		return word;
	endfunction

	task automatic send_beat(input logic [2:0] op, input logic [7:0] tx, input logic nack,
			input line_mode_t mode);
		logic        ee;
		logic        ra;
		logic [15:0] beat;
		case (mode)
			LINE_LOW: begin
				ee = 1'b0;
				ra = 1'b1;
			end
			LINE_HIGH: begin
				ee = 1'b1;
				ra = 1'b0;
			end
			default: begin
				ee = 1'($urandom_range(0, 1));
				ra = 1'($urandom_range(0, 1));
			end
		endcase
		beat = {2'b00, ra, ee, nack, tx, op};
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= beat;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bus_words_due.push_back(advance_bus_phase(beat));
		beats_sent++;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (bus_words_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic retarget_bus(input logic [1:0] bus);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= bus;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tgt = bus;
		n_retarget++;
		@(posedge clk);
	endtask

	function automatic logic [1:0] pick_bus();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return BUS_EEPROM;
		if (r < 6)
			return BUS_VOICE;
		if (r < 9)
			return BUS_FM;
		return 2'd3;
	endfunction

	// command beat, then ticks until the sequence completes
	task automatic run_cmd(input op_t op, input logic [7:0] tx, input logic nack,
			input line_mode_t mode);
		logic [2:0] tick_op;
		send_beat(op, tx, nack, mode);
		while (cur_cmd != OP_NONE) begin
			if ($urandom_range(0, 99) < retarget_pct)
				retarget_bus(pick_bus());
			tick_op = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(1, 7)) : OP_NONE;
			send_beat(tick_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), mode);
		end
	endtask

	task automatic random_transaction();
		int         r;
		int         nbytes;
		logic [7:0] addr;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			repeat ($urandom_range(1, 4))
				send_beat(($urandom_range(0, 1) != 0) ? 3'($urandom_range(5, 7)) : OP_NONE,
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LINE_RANDOM);
		end else if (r < 16) begin
			run_cmd(op_t'($urandom_range(1, 4)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), LINE_RANDOM);
		end else if (r < 24) begin
			retarget_bus(pick_bus());
		end else begin
			addr = 8'($urandom_range(0, 255));
			nbytes = $urandom_range(1, 2);
			run_cmd(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				LINE_RANDOM);
			run_cmd(OP_WRITE, addr, 1'($urandom_range(0, 1)), LINE_RANDOM);
			for (int i = 0; i < nbytes; i++) begin
				if (addr[0])
					run_cmd(OP_READ, 8'($urandom_range(0, 255)), (i == nbytes - 1),
						LINE_RANDOM);
				else
					run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						LINE_RANDOM);
			end
			if ($urandom_range(0, 9) != 0)
				run_cmd(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					LINE_RANDOM);
		end
	endtask

	task automatic test_idle_ticks();
		send_beat(OP_NONE, 8'h00, 1'b0, LINE_LOW);
		send_beat(OP_NONE, 8'hFF, 1'b1, LINE_HIGH);
		send_beat(3'd5, 8'hFF, 1'b1, LINE_LOW);
		send_beat(3'd6, 8'h00, 1'b0, LINE_HIGH);
		send_beat(3'd7, 8'hFF, 1'b1, LINE_RANDOM);
	endtask

	task automatic test_eeprom_transfers();
		run_cmd(OP_START, 8'h00, 1'b0, LINE_LOW);
		run_cmd(OP_WRITE, 8'hFF, 1'b0, LINE_LOW);
		run_cmd(OP_WRITE, 8'h00, 1'b1, LINE_HIGH);
		run_cmd(OP_WRITE, 8'hA5, 1'b0, LINE_RANDOM);
		run_cmd(OP_READ, 8'hFF, 1'b0, LINE_HIGH);
		run_cmd(OP_READ, 8'h00, 1'b1, LINE_LOW);
		run_cmd(OP_STOP, 8'hFF, 1'b1, LINE_HIGH);
	endtask

	task automatic test_radio_transfers();
		retarget_bus(BUS_VOICE);
		run_cmd(OP_START, 8'h00, 1'b0, LINE_RANDOM);
		run_cmd(OP_WRITE, 8'hC3, 1'b0, LINE_HIGH);
		run_cmd(OP_READ, 8'h00, 1'b1, LINE_RANDOM);
		run_cmd(OP_STOP, 8'h00, 1'b0, LINE_RANDOM);
		retarget_bus(BUS_FM);
		run_cmd(OP_START, 8'h00, 1'b0, LINE_RANDOM);
		run_cmd(OP_WRITE, 8'h3C, 1'b0, LINE_LOW);
		run_cmd(OP_READ, 8'h00, 1'b0, LINE_LOW);
		run_cmd(OP_STOP, 8'h00, 1'b0, LINE_RANDOM);
	endtask

	// unmapped target: pins stay put and the data line samples low
	task automatic test_unmapped_bus();
		retarget_bus(2'd3);
		run_cmd(OP_START, 8'h00, 1'b0, LINE_HIGH);
		run_cmd(OP_WRITE, 8'h5A, 1'b0, LINE_HIGH);
		run_cmd(OP_READ, 8'h00, 1'b1, LINE_HIGH);
		run_cmd(OP_STOP, 8'h00, 1'b0, LINE_HIGH);
		retarget_bus(BUS_EEPROM);
	endtask

	task automatic test_busy_commands();
		noise_pct = 100;
		run_cmd(OP_WRITE, 8'h96, 1'b0, LINE_RANDOM);
		run_cmd(OP_READ, 8'h00, 1'b1, LINE_RANDOM);
		noise_pct = 0;
	endtask

	task automatic test_retarget_mid_command();
		retarget_pct = 10;
		run_cmd(OP_START, 8'h00, 1'b0, LINE_RANDOM);
		run_cmd(OP_WRITE, 8'h69, 1'b0, LINE_RANDOM);
		run_cmd(OP_READ, 8'h00, 1'b0, LINE_RANDOM);
		run_cmd(OP_STOP, 8'h00, 1'b0, LINE_RANDOM);
		retarget_pct = 0;
		retarget_bus(BUS_EEPROM);
	endtask

	task automatic test_random_traffic();
		int phase_start;
		noise_pct = 6;
		retarget_pct = 1;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					ready_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 56;
					ready_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					ready_stall_pct = 56;
				end
				default: begin
					send_idle_pct = 33;
					ready_stall_pct = 33;
				end
			endcase
			phase_start = beats_sent;
			while (beats_sent - phase_start < 60)
				random_transaction();
			wait_drained();
		end
		noise_pct = 0;
		retarget_pct = 0;
		send_idle_pct = 0;
		ready_stall_pct = 0;
	endtask

	always @(posedge clk) begin
		logic [23:0] due;
		logic [23:0] mask;
		string       diff;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (bus_words_due.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result beat %h at %0t", m_axis_tdata, $realtime);
			end else begin
				due = bus_words_due.pop_front();
				diff = "";
				for (int i = 0; i < 12; i++) begin
					mask = (24'd1 << field_w[i]) - 24'd1;
					if (((due >> field_lsb[i]) & mask) !== ((m_axis_tdata >> field_lsb[i]) & mask))
						diff = {diff, " ", field_name[i]};
				end
				if (diff != "") begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("result %0d wrong in%s: expected %h, got %h", results_seen, diff,
							due, m_axis_tdata);
				end
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("i2c_master_byte_sequencer regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_eeprom_transfers();
		test_radio_transfers();
		test_unmapped_bus();
		test_busy_commands();
		test_retarget_mid_command();
		test_random_traffic();
		wait_drained();
		repeat (6)
			@(posedge clk);
		$display("%0d beats checked: %0d start, %0d stop, %0d write (%0d acked), %0d read (%0d NACKed)",
			results_seen, n_start, n_stop, n_write, n_acked, n_read, n_read_nack);
		$display("%0d commands ignored while busy, %0d bus selections, %0d mismatches",
			n_ignored, n_retarget, mismatch_cnt);
		if (mismatch_cnt == 0 && bus_words_due.size() == 0)
			$display("i2c_master_byte_sequencer regression: pass");
		else
			$display("i2c_master_byte_sequencer regression: fail");
		$finish;
	end

endmodule
